// ===== hw/rtl/fqmt_pkg.sv =====
`default_nettype none
package fqmt_pkg;

   localparam int TableEntriesDefault = 1024;
   localparam int TableWaysDefault    = 4;
   localparam logic [31:0] MinInit    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] recv_next_seq;
      logic [31:0] copied_seq_num;
      logic [31:0] write_seq_num;
      logic [31:0] unacked_seq;
      logic [31:0] process_id;
   } req_type;

   typedef struct packed {
      logic [31:0] flow_pid;
      logic [31:0] recv_queue_min;
      logic [31:0] recv_queue_max;
      logic [31:0] send_queue_min;
      logic [31:0] send_queue_max;
      logic        flow_created;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic [63:0] addrs;
      logic [31:0] ports;
      logic [31:0] pid;
      logic [31:0] recv_min;
      logic [31:0] recv_max;
      logic [31:0] send_min;
      logic [31:0] send_max;
   } slot_type;

endpackage
`default_nettype wire

// ===== hw/rtl/fqmt_hash.sv =====
`default_nettype none
// Iterative hash: one 32x32 multiply per cycle, 6 multiplies per key.
module fqmt_hash import fqmt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] addrs,
   input  wire logic [31:0] ports,
   output logic             done,
   output logic [31:0]      hash
);
   logic [31:0] h_ff, h_in;
   logic [3:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [31:0] t;
   logic [31:0] m;
   logic [31:0] x;
   logic [63:0] key_ff, key_in;

   always_comb begin
      h_in = h_ff; step_in = step_ff; busy_in = busy_ff; key_in = key_ff;
      done = 1'b0;
      x = 32'd0;
      case (step_ff[1:0])
         2'd0: x = h_ff ^ (h_ff >> 16);
         default: x = h_ff ^ (h_ff >> 15);
      endcase
      m = (step_ff[1:0] == 2'd0) ? 32'h7FEB352D : 32'h846CA68B;
      t = x * m;
      if (start) begin
         h_in = addrs[63:32]; step_in = 4'd0; busy_in = 1'b1; key_in = {addrs[31:0], ports};
      end else if (busy_ff) begin
         if (step_ff[1:0] == 2'd0) begin
            h_in = t; step_in = step_ff + 4'd1;
         end else begin
            h_in = t ^ (t >> 16);
            if (step_ff[3:2] == 2'd0) h_in = (t ^ (t >> 16)) ^ key_ff[63:32];
            else if (step_ff[3:2] == 2'd1) h_in = (t ^ (t >> 16)) ^ key_ff[31:0];
            step_in = {step_ff[3:2] + 2'd1, 2'd0};
            if (step_ff[3:2] == 2'd2) begin
               busy_in = 1'b0; done = 1'b1;
            end
         end
      end
      hash = t ^ (t >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; step_ff <= 4'd0;
      end else begin
         busy_ff <= busy_in; step_ff <= step_in;
      end
      h_ff <= h_in; key_ff <= key_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/flow_queue_minmax_table_top.sv =====
`default_nettype none
// Per-flow TCP queue depth min/max table. One beat in, one beat out; a new
// beat is accepted only in the idle state, after the last result is taken.
// Each item passes through the idle state, the six serial multiplies of the
// set hash, the four-step modulo-sets reduction (reciprocal estimate,
// back-multiply, subtract, one correction), forming the set base, one memory
// read and one compare per way, one final read, one write and one output
// state. After reset a clearing pass over all TABLE_ENTRIES entries runs
// before the first item is accepted.
module flow_queue_minmax_table_top import fqmt_pkg::*; #(
   parameter int TABLE_ENTRIES = TableEntriesDefault,
   parameter int TABLE_WAYS    = TableWaysDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int Sets0 = TABLE_ENTRIES / TABLE_WAYS;
   localparam int Sets  = (Sets0 > 0) ? Sets0 : 1;
   localparam int AW    = $clog2(TABLE_ENTRIES);
   localparam int WW    = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
   localparam logic [31:0] Recip = 32'((64'd1 << 32) / Sets);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_HASH  = 8'b0000_0100,
      ST_MOD   = 8'b0000_1000,
      ST_READ  = 8'b0001_0000,
      ST_CMP   = 8'b0010_0000,
      ST_WRITE = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic [AW:0] clr_ff, clr_in;
   logic [31:0] mod_ff, mod_in;
   logic [5:0]  mbit_ff, mbit_in;
   logic [31:0] hval_ff, hval_in;
   logic [WW:0] way_ff, way_in;
   logic        hit_ff, hit_in, free_ff, free_in;
   logic [AW-1:0] slot_ff, slot_in, free_slot_ff, free_slot_in;
   logic [AW:0] base_ff, base_in;

   logic        mem_valid [TABLE_ENTRIES];
   slot_type    mem [TABLE_ENTRIES];
   logic        rd_valid_ff;
   slot_type    rd_ff;
   slot_type    rd_hit_ff;
   logic [AW:0] rd_idx;
   logic        we, vwe;
   logic [AW-1:0] wa;
   logic        wv;
   slot_type    wd;

   logic        h_done;
   logic [31:0] h_out;
   logic [63:0] key_addrs;
   logic [31:0] key_ports, rq, wq;
   logic [63:0] prod;
   slot_type    cur;

   assign key_addrs = {req_ff.src_addr, req_ff.dst_addr};
   assign key_ports = {req_ff.src_port, req_ff.dst_port};

   fqmt_hash u_hash (
      .clock(clock), .reset(reset), .start(state_ff == ST_IDLE && req_valid),
      .addrs({req_data.src_addr, req_data.dst_addr}),
      .ports({req_data.src_port, req_data.dst_port}),
      .done(h_done), .hash(h_out)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;
   assign rd_idx    = base_ff + {{(AW - WW){1'b0}}, way_ff};

   always_comb begin
      state_in = state_ff; req_in = req_ff; rsp_in = rsp_ff; clr_in = clr_ff;
      mod_in = mod_ff; mbit_in = mbit_ff; hval_in = hval_ff; way_in = way_ff;
      hit_in = hit_ff; free_in = free_ff; slot_in = slot_ff;
      free_slot_in = free_slot_ff; base_in = base_ff;
      we = 1'b0; vwe = 1'b0; wa = clr_ff[AW-1:0]; wv = 1'b0; wd = rd_ff;
      rq = req_ff.recv_next_seq - req_ff.copied_seq_num;
      if (rq[31]) rq = 32'd0;
      wq = req_ff.write_seq_num - req_ff.unacked_seq;
      prod = {32'd0, hval_ff} * {32'd0, Recip};
      cur = rd_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            vwe = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW + 1)'(TABLE_ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (req_valid) begin
            req_in = req_data; state_in = ST_HASH;
         end
         ST_HASH: if (h_done) begin
            hval_in = h_out; mod_in = 32'd0; mbit_in = 6'd0; state_in = ST_MOD;
         end
         ST_MOD: begin
            // quotient estimate is exact or one low
            mbit_in = mbit_ff + 6'd1;
            case (mbit_ff[1:0])
               2'd0: mod_in = prod[63:32];
               2'd1: mod_in = mod_ff * 32'(Sets);
               2'd2: mod_in = hval_ff - mod_ff;
               default: begin
                  if (Sets == 1) mod_in = 32'd0;
                  else if (mod_ff >= 32'(Sets)) mod_in = mod_ff - 32'(Sets);
                  mbit_in = 6'd32;
                  state_in = ST_READ; way_in = '0; hit_in = 1'b0; free_in = 1'b0;
               end
            endcase
         end
         ST_READ: begin
            if (mbit_ff == 6'd32) base_in = (AW + 1)'(mod_ff * 32'(TABLE_WAYS));
            mbit_in = 6'd0;
            if (mbit_ff != 6'd32 && (way_ff == (WW + 1)'(TABLE_WAYS) ||
                rd_idx >= (AW + 1)'(TABLE_ENTRIES)))
               state_in = ST_WRITE;
            else if (mbit_ff != 6'd32)
               state_in = ST_CMP;
         end
         ST_CMP: begin
            if (rd_valid_ff) begin
               if (!hit_ff && rd_ff.addrs == key_addrs && rd_ff.ports == key_ports) begin
                  hit_in = 1'b1; slot_in = rd_idx[AW-1:0];
               end
            end else if (!free_ff) begin
               free_in = 1'b1; free_slot_in = rd_idx[AW-1:0];
            end
            way_in = way_ff + 1'b1;
            state_in = ST_READ;
         end
         ST_WRITE: begin
            state_in = ST_OUT;
            rsp_in = '0;
            if (!hit_ff && !free_ff) begin
               rsp_in.table_full = 1'b1;
            end else begin
               if (!hit_ff) begin
                  wa = free_slot_ff;
                  cur.addrs = key_addrs; cur.ports = key_ports;
                  cur.recv_min = MinInit; cur.recv_max = 32'd0;
                  cur.send_min = MinInit; cur.send_max = 32'd0;
                  rsp_in.flow_created = 1'b1;
               end else begin
                  wa = slot_ff;
                  cur = rd_hit_ff;
               end
               cur.pid = req_ff.process_id;
               if (rq > cur.recv_max) cur.recv_max = rq;
               if (rq < cur.recv_min) cur.recv_min = rq;
               if (wq > cur.send_max) cur.send_max = wq;
               if (wq < cur.send_min) cur.send_min = wq;
               wd = cur; we = 1'b1; vwe = 1'b1; wv = 1'b1;
               rsp_in.flow_pid = cur.pid;
               rsp_in.recv_queue_min = cur.recv_min;
               rsp_in.recv_queue_max = cur.recv_max;
               rsp_in.send_queue_min = cur.send_min;
               rsp_in.send_queue_max = cur.send_max;
            end
         end
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CMP && rd_valid_ff && !hit_ff &&
          rd_ff.addrs == key_addrs && rd_ff.ports == key_ports)
         rd_hit_ff <= rd_ff;
   end

   always_ff @(posedge clock) begin
      if (vwe) mem_valid[wa] <= wv;
      if (we) mem[wa] <= wd;
      rd_valid_ff <= mem_valid[rd_idx[AW-1:0]];
      rd_ff <= mem[rd_idx[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
      end
      req_ff <= req_in; rsp_ff <= rsp_in; mod_ff <= mod_in; mbit_ff <= mbit_in;
      hval_ff <= hval_in; way_ff <= way_in; hit_ff <= hit_in; free_ff <= free_in;
      slot_ff <= slot_in; free_slot_ff <= free_slot_in; base_ff <= base_in;
   end

   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.table_full && rsp_data.flow_created)) else $error("full and created");
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.table_full) |-> rsp_data.send_queue_max == 32'd0)
      else $error("full beat carries stats");
   a_minmax: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.table_full) |->
      rsp_data.recv_queue_min <= rsp_data.recv_queue_max) else $error("min above max");
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result held");
endmodule
`default_nettype wire
